### hw/rtl/mrc_pkg.sv
`default_nettype none

package mrc_pkg;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam int HDR_LEN  = 3;
    localparam int PAY_LEN  = 4;
    localparam int POS_W    = 9;
    localparam int LIM_W    = 13;

    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam int CFG_ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_VOLT_ADDR  = 3'd0,
        REG_TEMP_ADDR  = 3'd1,
        REG_LEVEL_ADDR = 3'd2,
        REG_VOLT_HIGH  = 3'd3,
        REG_VOLT_LOW   = 3'd4,
        REG_TEMP_HIGH  = 3'd5,
        REG_TEMP_LOW   = 3'd6
    } cfg_idx_t;

    localparam logic [7:0]       RST_VOLT_ADDR  = 8'd1;
    localparam logic [7:0]       RST_TEMP_ADDR  = 8'd5;
    localparam logic [7:0]       RST_LEVEL_ADDR = 8'd4;
    localparam logic [LIM_W-1:0] RST_VOLT_HIGH  = 13'd6553;
    localparam logic [LIM_W-1:0] RST_VOLT_LOW   = 13'd0;
    localparam logic [LIM_W-1:0] RST_TEMP_HIGH  = 13'd30;
    localparam logic [LIM_W-1:0] RST_TEMP_LOW   = 13'd15;

    typedef enum logic [1:0] {
        KIND_VOLTAGE     = 2'd0,
        KIND_TEMPERATURE = 2'd1,
        KIND_LEVEL       = 2'd2,
        KIND_UNKNOWN     = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0]       volt_addr;
        logic [7:0]       temp_addr;
        logic [7:0]       level_addr;
        logic [LIM_W-1:0] volt_high;
        logic [LIM_W-1:0] volt_low;
        logic [LIM_W-1:0] temp_high;
        logic [LIM_W-1:0] temp_low;
    } cfg_t;

    // One finished frame handed from the front to the back.
    typedef struct packed {
        logic [PAY_LEN-1:0][7:0] payload;
        logic                    crc_ok;
        logic [7:0]              byte_count;
        logic [7:0]              function_code;
        logic [7:0]              device_addr;
    } frame_rec_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mrc_front.sv
`default_nettype none

module mrc_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,    // [7:0] rx_byte
    input  wire logic [0:0]         s_tuser,    // [0] frame_start
    input  wire logic               q_full,
    output logic                    push,
    output mrc_pkg::frame_rec_t     push_rec
);
    import mrc_pkg::*;

    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    in_frame_reg, in_frame_next;
    logic [15:0]             crc_reg, crc_next;
    logic [7:0]              crc_lo_reg, crc_lo_next;
    logic [HDR_LEN-1:0][7:0] hdr_reg, hdr_next;
    logic [PAY_LEN-1:0][7:0] pay_reg, pay_next;

    logic             beat, take, fs;
    logic [7:0]       b;
    logic [POS_W-1:0] pos_cur, lim;
    logic [15:0]      crc_cur;
    logic             last;

    assign s_tready = !q_full;
    assign beat     = s_tvalid && s_tready;
    assign fs       = s_tuser[0];
    assign b        = s_tdata;
    assign take     = beat && (fs || in_frame_reg);
    assign pos_cur  = fs ? '0 : pos_reg;
    assign crc_cur  = fs ? CRC_INIT : crc_reg;

    always_comb begin
        pos_next      = pos_reg;
        in_frame_next = in_frame_reg;
        crc_next      = crc_reg;
        crc_lo_next   = crc_lo_reg;
        hdr_next      = hdr_reg;
        pay_next      = pay_reg;
        last          = 1'b0;
        lim           = '0;

        if (take) begin
            if (fs) begin
                pay_next = '0;
            end
            if (pos_cur < POS_W'(HDR_LEN)) begin
                hdr_next[pos_cur[1:0]] = b;
            end else if (pos_cur < POS_W'(HDR_LEN + PAY_LEN)) begin
                // positions 3..6 map to payload slots 0..3
                pay_next[pos_cur[1:0] + 2'd1] = b;
            end

            lim = {1'b0, hdr_next[2]} + POS_W'(HDR_LEN);
            in_frame_next = 1'b1;
            if (pos_cur < POS_W'(HDR_LEN) || pos_cur < lim) begin
                crc_next = crc_byte(crc_cur, b);
                pos_next = pos_cur + 1'b1;
            end else if (pos_cur == lim) begin
                crc_lo_next = b;
                crc_next    = crc_cur;
                pos_next    = pos_cur + 1'b1;
            end else begin
                last          = 1'b1;
                in_frame_next = 1'b0;
                pos_next      = '0;
            end
        end
    end

    assign push                   = take && last;
    assign push_rec.device_addr   = hdr_next[0];
    assign push_rec.function_code = hdr_next[1];
    assign push_rec.byte_count    = hdr_next[2];
    assign push_rec.crc_ok        = ({b, crc_lo_reg} == crc_cur);
    assign push_rec.payload       = pay_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            in_frame_reg <= 1'b0;
            crc_reg      <= CRC_INIT;
        end else begin
            pos_reg      <= pos_next;
            in_frame_reg <= in_frame_next;
            crc_reg      <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_lo_reg <= crc_lo_next;
        hdr_reg    <= hdr_next;
        pay_reg    <= pay_next;
    end

endmodule

`default_nettype wire

### hw/rtl/mrc_queue.sv
`default_nettype none

module mrc_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire mrc_pkg::frame_rec_t  push_rec,
    input  wire logic                 pop,
    output mrc_pkg::frame_rec_t       pop_rec,
    output logic                      empty,
    output logic                      full
);
    import mrc_pkg::*;

    frame_rec_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_push_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == QCNT_W'(QDEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers out of step with count");

endmodule

`default_nettype wire

### hw/rtl/mrc_back.sv
`default_nettype none

module mrc_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mrc_pkg::cfg_t        cfg,
    input  wire logic                 q_empty,
    input  wire mrc_pkg::frame_rec_t  q_rec,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [47:0]               m_tdata,  // [7:0] device_addr, [15:8] function_code,
                                                // [23:16] byte_count, [24] crc_ok,
                                                // [40:25] reading, [41] alarm, rest zero
    output logic [1:0]                m_tuser   // [1:0] kind
);
    import mrc_pkg::*;

    logic        valid_reg;
    logic [7:0]  da_reg, fc_reg, bc_reg;
    logic        ok_reg;
    kind_t       kind_reg;
    logic [15:0] reading_reg;
    logic        alarm_reg;

    kind_t       kind_c;
    logic [15:0] reading_c;
    logic        alarm_c;
    logic [16:0] hi10, lo10;
    logic [LIM_W-1:0] hi, lo;

    assign q_pop = !q_empty && (!valid_reg || m_tready);

    always_comb begin
        if (q_rec.device_addr == cfg.volt_addr) begin
            kind_c = KIND_VOLTAGE;
        end else if (q_rec.device_addr == cfg.temp_addr) begin
            kind_c = KIND_TEMPERATURE;
        end else if (q_rec.device_addr == cfg.level_addr) begin
            kind_c = KIND_LEVEL;
        end else begin
            kind_c = KIND_UNKNOWN;
        end

        hi = (kind_c == KIND_VOLTAGE) ? cfg.volt_high : cfg.temp_high;
        lo = (kind_c == KIND_VOLTAGE) ? cfg.volt_low  : cfg.temp_low;
        // x10 as shift and add
        hi10 = {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0};
        lo10 = {1'b0, lo, 3'b000} + {3'b000, lo, 1'b0};

        reading_c = '0;
        alarm_c   = 1'b0;
        if (q_rec.crc_ok) begin
            case (kind_c)
                KIND_VOLTAGE: begin
                    reading_c = {q_rec.payload[0], q_rec.payload[1]};
                    alarm_c   = ({1'b0, reading_c} > hi10) || ({1'b0, reading_c} < lo10);
                end
                KIND_TEMPERATURE: begin
                    reading_c = {q_rec.payload[2], q_rec.payload[3]};
                    alarm_c   = ({1'b0, reading_c} > hi10) || ({1'b0, reading_c} < lo10);
                end
                KIND_LEVEL: begin
                    reading_c = {8'h00, q_rec.payload[1]};
                    alarm_c   = (reading_c != '0);
                end
                default: begin
                    reading_c = '0;
                    alarm_c   = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            da_reg      <= q_rec.device_addr;
            fc_reg      <= q_rec.function_code;
            bc_reg      <= q_rec.byte_count;
            ok_reg      <= q_rec.crc_ok;
            kind_reg    <= kind_c;
            reading_reg <= reading_c;
            alarm_reg   <= alarm_c;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b000000, alarm_reg, reading_reg, ok_reg, bc_reg, fc_reg, da_reg};
    assign m_tuser  = kind_reg;

    a_bad_crc_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !ok_reg) |-> (reading_reg == '0 && !alarm_reg))
        else $error("failed CRC result carries a reading or alarm");

    a_unknown_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg == KIND_UNKNOWN) |-> (reading_reg == '0 && !alarm_reg))
        else $error("unknown address result carries a reading or alarm");

    a_level_alarm: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg == KIND_LEVEL) |-> (alarm_reg == (reading_reg != '0)))
        else $error("level alarm does not follow level");

endmodule

`default_nettype wire

### hw/rtl/modbus_reply_checker.sv
// Reply frame checker for a byte stream of RTU replies.
// Input channel s_*: one received byte per beat in s_tdata, s_tuser[0] set on
// the first byte of a frame (a new start drops any partial frame). Bytes seen
// outside a frame are dropped. Output channel m_*: one beat per complete frame
// with header, CRC match, reading and alarm in m_tdata, the decoded kind in
// m_tuser. Registers (addresses, alarm limits) sit on the APB port at 4*i and
// should be written while no frame is in flight.
// Throughput: one byte per cycle while the frame queue is not full; CRC-16 is
// updated a whole byte per cycle. The edge that takes the last CRC byte
// writes the frame queue; the result stage then loads from the queue as soon
// as it holds no result or its result is being taken.
// A two-entry frame queue sits between the byte front end and the result
// stage; s_tready drops only while that queue is full, which takes a result
// held by a low m_tready plus two more finished frames behind it.
// Bytes of the next frame keep flowing while a result waits to be taken.
// Reset (aresetn low, synchronous) clears the frame tracker, the queue and
// the output valid, and loads the register defaults.
`default_nettype none

module modbus_reply_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]  s_tuser,   // [0] frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] device_addr, [15:8] function_code,
                                        // [23:16] byte_count, [24] crc_ok,
                                        // [40:25] reading, [41] alarm, rest zero
    output logic [1:0]       m_tuser,   // [1:0] kind
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mrc_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    cfg_idx_t   widx;
    logic       wr_en;

    logic       q_full, q_empty, q_push, q_pop;
    frame_rec_t push_rec, pop_rec;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign widx   = cfg_idx_t'(paddr[4:2]);

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (widx)
                REG_VOLT_ADDR:  cfg_next.volt_addr  = pwdata[7:0];
                REG_TEMP_ADDR:  cfg_next.temp_addr  = pwdata[7:0];
                REG_LEVEL_ADDR: cfg_next.level_addr = pwdata[7:0];
                REG_VOLT_HIGH:  cfg_next.volt_high  = pwdata[LIM_W-1:0];
                REG_VOLT_LOW:   cfg_next.volt_low   = pwdata[LIM_W-1:0];
                REG_TEMP_HIGH:  cfg_next.temp_high  = pwdata[LIM_W-1:0];
                REG_TEMP_LOW:   cfg_next.temp_low   = pwdata[LIM_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (widx)
            REG_VOLT_ADDR:  prdata = {24'd0, cfg_reg.volt_addr};
            REG_TEMP_ADDR:  prdata = {24'd0, cfg_reg.temp_addr};
            REG_LEVEL_ADDR: prdata = {24'd0, cfg_reg.level_addr};
            REG_VOLT_HIGH:  prdata = {19'd0, cfg_reg.volt_high};
            REG_VOLT_LOW:   prdata = {19'd0, cfg_reg.volt_low};
            REG_TEMP_HIGH:  prdata = {19'd0, cfg_reg.temp_high};
            REG_TEMP_LOW:   prdata = {19'd0, cfg_reg.temp_low};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.volt_addr  <= RST_VOLT_ADDR;
            cfg_reg.temp_addr  <= RST_TEMP_ADDR;
            cfg_reg.level_addr <= RST_LEVEL_ADDR;
            cfg_reg.volt_high  <= RST_VOLT_HIGH;
            cfg_reg.volt_low   <= RST_VOLT_LOW;
            cfg_reg.temp_high  <= RST_TEMP_HIGH;
            cfg_reg.temp_low   <= RST_TEMP_LOW;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mrc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (q_push),
        .push_rec (push_rec)
    );

    mrc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .pop_rec  (pop_rec),
        .empty    (q_empty),
        .full     (q_full)
    );

    mrc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_rec    (pop_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### test/tb_modbus_reply_checker.sv
`timescale 1ns / 100ps

module tb_modbus_reply_checker;
    import mrc_pkg::*;

    localparam logic [15:0] CRC_SEED           = 16'hFFFF;
    localparam logic [15:0] CRC_REFLECTED_POLY = 16'hA001;
    localparam logic [2:0]  REG_SPARE          = 3'd7;   // first index past the register list
    localparam int          STALL_LIMIT        = 2000;
    localparam int          MAX_PRINTED        = 30;

    typedef struct packed {
        logic [7:0]  device_addr;
        logic [7:0]  function_code;
        logic [7:0]  byte_count;
        logic        crc_ok;
        kind_t       kind;
        logic [15:0] reading;
        logic        alarm;
    } reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;     // [7:0] rx_byte
    logic [0:0]  s_tuser  = 1'b0;      // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;              // [7:0] device_addr, [15:8] function_code,
                                       // [23:16] byte_count, [24] crc_ok,
                                       // [40:25] reading, [41] alarm
    logic [1:0]  m_tuser;              // [1:0] kind
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = 5'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // register mirror and frame tracker of the predictor
    cfg_t        dev_cfg = '{RST_VOLT_ADDR, RST_TEMP_ADDR, RST_LEVEL_ADDR,
                             RST_VOLT_HIGH, RST_VOLT_LOW, RST_TEMP_HIGH, RST_TEMP_LOW};
    int          fr_pos  = 0;
    bit          fr_open = 1'b0;
    logic [15:0] fr_crc  = 16'hFFFF;
    logic [7:0]  hdr [3] = '{default: 8'h00};
    logic [7:0]  pay [4] = '{default: 8'h00};
    logic [7:0]  crc_lo  = 8'h00;

    reply_t      replies_due[$];
    logic [7:0]  frame_buf[$];

    int tx_idle_pct     = 33;
    int rx_idle_pct     = 87;
    int errors          = 0;
    int bytes_sent      = 0;
    int used_bytes      = 0;
    int replies_checked = 0;
    int reg_writes      = 0;
    int stall_cycles    = 0;

    modbus_reply_checker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_REFLECTED_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic bit out_of_window(input int v, input int hi, input int lo);
        return (v > hi * 10) || (v < lo * 10);
    endfunction

    // Advance the frame tracker by one accepted beat; queues a reply on the
    // closing CRC byte. Returns 0 for a byte dropped outside any frame.
    function automatic bit take_reply_byte(input logic [7:0] b, input bit start);
        reply_t      r;
        logic [15:0] rx_crc;
        if (start) begin
            fr_pos  = 0;
            fr_open = 1'b1;
            fr_crc  = CRC_SEED;
            pay     = '{default: 8'h00};
        end else if (!fr_open) begin
            return 1'b0;
        end
        if (fr_pos < 3) begin
            hdr[fr_pos] = b;
        end else if (fr_pos < 7) begin
            pay[fr_pos - 3] = b;
        end
        if (fr_pos < 3 || fr_pos < int'(hdr[2]) + 3) begin
            fr_crc = crc16_step(fr_crc, b);
            fr_pos++;
            return 1'b1;
        end
        if (fr_pos == int'(hdr[2]) + 3) begin
            crc_lo = b;
            fr_pos++;
            return 1'b1;
        end
        fr_open         = 1'b0;
        fr_pos          = 0;
        rx_crc          = {b, crc_lo};
        r.device_addr   = hdr[0];
        r.function_code = hdr[1];
        r.byte_count    = hdr[2];
        r.crc_ok        = (rx_crc == fr_crc);
        if (hdr[0] == dev_cfg.volt_addr) begin
            r.kind = KIND_VOLTAGE;
        end else if (hdr[0] == dev_cfg.temp_addr) begin
            r.kind = KIND_TEMPERATURE;
        end else if (hdr[0] == dev_cfg.level_addr) begin
            r.kind = KIND_LEVEL;
        end else begin
            r.kind = KIND_UNKNOWN;
        end
        r.reading = 16'd0;
        r.alarm   = 1'b0;
        if (r.crc_ok) begin
            case (r.kind)
                KIND_VOLTAGE: begin
                    r.reading = {pay[0], pay[1]};
                    r.alarm   = out_of_window(r.reading, dev_cfg.volt_high, dev_cfg.volt_low);
                end
                KIND_TEMPERATURE: begin
                    r.reading = {pay[2], pay[3]};
                    r.alarm   = out_of_window(r.reading, dev_cfg.temp_high, dev_cfg.temp_low);
                end
                KIND_LEVEL: begin
                    r.reading = {8'h00, pay[1]};
                    r.alarm   = (pay[1] != 8'h00);
                end
                default: ;
            endcase
        end
        replies_due.push_back(r);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTED) begin
            $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        end
    endtask

    // Beats are sampled at the falling edge, so both sides are settled.
    always @(negedge aclk) begin : reply_monitor
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                report_mismatch("reply with none pending", m_tdata[31:0], 32'd0);
            end else begin
                want = replies_due.pop_front();
                if (m_tdata[7:0] !== want.device_addr)
                    report_mismatch("device_addr", m_tdata[7:0], want.device_addr);
                if (m_tdata[15:8] !== want.function_code)
                    report_mismatch("function_code", m_tdata[15:8], want.function_code);
                if (m_tdata[23:16] !== want.byte_count)
                    report_mismatch("byte_count", m_tdata[23:16], want.byte_count);
                if (m_tdata[24] !== want.crc_ok)
                    report_mismatch("crc_ok", m_tdata[24], want.crc_ok);
                if (m_tdata[40:25] !== want.reading)
                    report_mismatch("reading", m_tdata[40:25], want.reading);
                if (m_tdata[41] !== want.alarm)
                    report_mismatch("alarm", m_tdata[41], want.alarm);
                if (m_tdata[47:42] !== 6'd0)
                    report_mismatch("tdata padding", m_tdata[47:42], 32'd0);
                if (m_tuser !== want.kind)
                    report_mismatch("kind", m_tuser, want.kind);
            end
            replies_checked++;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d replies outstanding",
                         stall_cycles, replies_due.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit start);
        bit rdy;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        bytes_sent++;
        if (take_reply_byte(b, start)) used_bytes++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // back to idle so the next write starts on a fresh edge
        @(posedge aclk);
        reg_writes++;
        case (idx)
            REG_VOLT_ADDR:  dev_cfg.volt_addr  = value[7:0];
            REG_TEMP_ADDR:  dev_cfg.temp_addr  = value[7:0];
            REG_LEVEL_ADDR: dev_cfg.level_addr = value[7:0];
            REG_VOLT_HIGH:  dev_cfg.volt_high  = value[LIM_W-1:0];
            REG_VOLT_LOW:   dev_cfg.volt_low   = value[LIM_W-1:0];
            REG_TEMP_HIGH:  dev_cfg.temp_high  = value[LIM_W-1:0];
            REG_TEMP_LOW:   dev_cfg.temp_low   = value[LIM_W-1:0];
            default: ;
        endcase
    endtask

    // Stop the input stream and let every pending reply drain out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic open_frame(input logic [7:0] addr, input logic [7:0] fc,
                              input logic [7:0] cnt);
        frame_buf.delete();
        frame_buf.push_back(addr);
        frame_buf.push_back(fc);
        frame_buf.push_back(cnt);
        for (int i = 0; i < cnt; i++) frame_buf.push_back($urandom_range(255));
    endtask

    // big-endian word at frame offset at, only where both bytes are data
    task automatic put_word(input int at, input logic [15:0] w);
        if (at + 1 < frame_buf.size()) begin
            frame_buf[at]     = w[15:8];
            frame_buf[at + 1] = w[7:0];
        end
    endtask

    task automatic seal_frame(input bit corrupt);
        logic [15:0] c;
        c = CRC_SEED;
        foreach (frame_buf[i]) c = crc16_step(c, frame_buf[i]);
        if (corrupt) c = c ^ (16'd1 << $urandom_range(15));
        frame_buf.push_back(c[7:0]);
        frame_buf.push_back(c[15:8]);
    endtask

    task automatic send_frame(input int n);
        for (int i = 0; i < n; i++) send_byte(frame_buf[i], i == 0);
    endtask

    task automatic directed_reply(input logic [7:0] addr, input logic [7:0] fc,
                                  input logic [7:0] cnt, input int at,
                                  input logic [15:0] w, input bit corrupt);
        open_frame(addr, fc, cnt);
        put_word(at, w);
        seal_frame(corrupt);
        send_frame(frame_buf.size());
    endtask

    function automatic logic [15:0] pick_reading(input logic [LIM_W-1:0] hi,
                                                 input logic [LIM_W-1:0] lo);
        int v;
        case ($urandom_range(3))
            0:       v = $urandom_range(65535);
            1:       v = int'(hi) * 10 + int'($urandom_range(2)) - 1;
            2:       v = int'(lo) * 10 + int'($urandom_range(2)) - 1;
            default: v = int'($urandom_range(65535)) & 16'h00FF;
        endcase
        return v[15:0];
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'd6553;
            default: return $urandom_range(6553);
        endcase
    endfunction

    task automatic random_config();
        logic [7:0] a;
        logic [7:0] t;
        a = $urandom_range(255);
        t = ($urandom_range(5) == 0) ? a : 8'($urandom_range(255));
        write_reg(REG_VOLT_ADDR, a);
        write_reg(REG_TEMP_ADDR, t);
        write_reg(REG_LEVEL_ADDR, ($urandom_range(5) == 0) ? t : 8'($urandom_range(255)));
        write_reg(REG_VOLT_HIGH, pick_limit());
        write_reg(REG_VOLT_LOW, pick_limit());
        write_reg(REG_TEMP_HIGH, pick_limit());
        write_reg(REG_TEMP_LOW, pick_limit());
    endtask

    task automatic random_reply(input bit cut_short);
        logic [7:0] addr;
        logic [7:0] cnt;
        int         pick;
        int         n;
        pick = $urandom_range(3);
        case (pick)
            0:       addr = dev_cfg.volt_addr;
            1:       addr = dev_cfg.temp_addr;
            2:       addr = dev_cfg.level_addr;
            default: addr = $urandom_range(255);
        endcase
        n = $urandom_range(99);
        if (n < 90) begin
            cnt = $urandom_range(8);
        end else if (n < 98) begin
            cnt = $urandom_range(40, 9);
        end else begin
            cnt = $urandom_range(255, 41);
        end
        open_frame(addr, $urandom_range(255), cnt);
        put_word(3, pick_reading(dev_cfg.volt_high, dev_cfg.volt_low));
        put_word(5, pick_reading(dev_cfg.temp_high, dev_cfg.temp_low));
        // level byte at offset 4: zero half the time
        if (frame_buf.size() > 5 && $urandom_range(1)) frame_buf[4] = 8'h00;
        seal_frame($urandom_range(9) == 0);
        send_frame(cut_short ? $urandom_range(frame_buf.size() - 1, 1) : frame_buf.size());
    endtask

    // register defaults: voltage at 1, temperature at 5, level at 4
    task automatic test_reset_config();
        directed_reply(8'h01, 8'h03, 8'd4, 3, 16'h1234, 1'b0);
        directed_reply(8'h01, 8'h03, 8'd4, 3, 16'hFFFF, 1'b0);
        directed_reply(8'h05, 8'h04, 8'd4, 5, 16'd149, 1'b0);
        directed_reply(8'h05, 8'h04, 8'd4, 5, 16'd150, 1'b0);
        directed_reply(8'h05, 8'h04, 8'd4, 5, 16'd300, 1'b0);
        directed_reply(8'h05, 8'h04, 8'd4, 5, 16'd301, 1'b0);
        directed_reply(8'h04, 8'h03, 8'd2, 3, 16'hAA00, 1'b0);
        directed_reply(8'h04, 8'h03, 8'd2, 3, 16'h00FF, 1'b0);
        directed_reply(8'h09, 8'h03, 8'd4, 3, 16'h0101, 1'b0);
        directed_reply(8'h01, 8'h03, 8'd4, 3, 16'hFFFF, 1'b1);
    endtask

    task automatic test_frame_edges();
        // short counts: CRC bytes land in the captured payload, the rest stays zero
        directed_reply(8'h01, 8'h03, 8'd0, 3, 16'h0000, 1'b0);
        directed_reply(8'h05, 8'h03, 8'd1, 3, 16'h0000, 1'b0);
        directed_reply(8'h00, 8'h00, 8'd0, 3, 16'h0000, 1'b0);
        directed_reply(8'hFF, 8'hFF, 8'd255, 3, 16'hFFFF, 1'b0);
        // stray bytes with no frame open
        for (int i = 0; i < 3; i++) send_byte($urandom_range(255), 1'b0);
        // partial frames dropped by a new frame start
        open_frame(8'h01, 8'h03, 8'd4);
        seal_frame(1'b0);
        send_frame(5);
        send_frame(2);
        directed_reply(8'h05, 8'h03, 8'd4, 5, 16'd200, 1'b1);
        directed_reply(8'h05, 8'h03, 8'd4, 5, 16'd200, 1'b0);
    endtask

    task automatic test_register_extremes();
        settle();
        // all addresses equal: voltage takes precedence; zero-width window
        write_reg(REG_VOLT_ADDR, 32'd0);
        write_reg(REG_TEMP_ADDR, 32'd0);
        write_reg(REG_LEVEL_ADDR, 32'd0);
        write_reg(REG_VOLT_HIGH, 32'd0);
        write_reg(REG_VOLT_LOW, 32'd0);
        write_reg(REG_TEMP_HIGH, 32'd6553);
        write_reg(REG_TEMP_LOW, 32'd6553);
        directed_reply(8'h00, 8'h03, 8'd4, 3, 16'd0, 1'b0);
        directed_reply(8'h00, 8'h03, 8'd4, 3, 16'd1, 1'b0);
        settle();
        // temperature and level share an address: temperature wins
        write_reg(REG_VOLT_ADDR, 32'hABCD_E080);   // upper bits must be dropped
        write_reg(REG_TEMP_ADDR, 32'd255);
        write_reg(REG_LEVEL_ADDR, 32'd255);
        write_reg(REG_VOLT_HIGH, 32'hFFFF_E123);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        directed_reply(8'hFF, 8'h04, 8'd4, 5, 16'd65530, 1'b0);
        directed_reply(8'hFF, 8'h04, 8'd4, 5, 16'd65529, 1'b0);
        directed_reply(8'hFF, 8'h04, 8'd4, 5, 16'd65531, 1'b0);
        directed_reply(8'h80, 8'h03, 8'd2, 3, 16'd2910, 1'b0);
        directed_reply(8'h80, 8'h03, 8'd2, 3, 16'd2911, 1'b0);
        settle();
        write_reg(REG_LEVEL_ADDR, 32'h7F);
        directed_reply(8'h7F, 8'h03, 8'd2, 3, 16'h5500, 1'b0);
        directed_reply(8'h7F, 8'h03, 8'd2, 3, 16'h5501, 1'b0);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int target);
        int first_used;
        int r;
        int n;
        settle();
        random_config();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        first_used  = used_bytes;
        while (used_bytes - first_used < target) begin
            r = $urandom_range(99);
            if (r < 75) begin
                random_reply(1'b0);
            end else if (r < 85) begin
                random_reply(1'b1);
            end else if (r < 92) begin
                n = $urandom_range(4, 1);
                for (int i = 0; i < n; i++) send_byte($urandom_range(255), 1'b0);
            end else begin
                n = $urandom_range(6, 1);
                for (int i = 0; i < n; i++)
                    send_byte($urandom_range(255), $urandom_range(4) == 0);
            end
        end
        // close on a whole frame so no frame is open across the next register write
        random_reply(1'b0);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_config();
        test_frame_edges();
        test_register_extremes();
        test_random_traffic(33, 87, 230);
        test_random_traffic(87, 33, 230);
        test_random_traffic(0, 0, 230);
        settle();
        repeat (10) @(posedge aclk);
        $display("covered %0d bytes (%0d inside frames), %0d replies checked, %0d register writes",
                 bytes_sent, used_bytes, replies_checked, reg_writes);
        $display("mismatches: %0d", errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
